FILE: design/pfrt_pkg.sv
// Shared types and constants for the page frame region table.
package pfrt_pkg;

	localparam int PAGE_SHIFT = 12;
	localparam int PAGE_W     = 52;

	typedef enum logic [1:0] {
		OP_APPEND  = 2'd0,
		OP_REWRITE = 2'd1,
		OP_RESERVE = 2'd2,
		OP_TOTALS  = 2'd3
	} op_t;

	typedef struct packed {
		logic [63:0] base;
		logic [51:0] pages;
		logic [3:0]  st;
		logic [31:0] usage;
		logic [31:0] owner;
		logic [31:0] source;
		logic [63:0] attrs;
	} region_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_APP_RD,
		ST_APP_DO,
		ST_RW_CHK,
		ST_RW_RD,
		ST_RW_WAIT,
		ST_RW_P0,
		ST_RW_P1,
		ST_RW_P2,
		ST_RW_FIN,
		ST_CP_RD,
		ST_CP_WAIT,
		ST_CP_DO,
		ST_TOT_RD,
		ST_TOT_ADD,
		ST_DONE
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load_in;      // capture input item
		logic rw_setup;     // compute range for rewrite/reserve
		logic tab_rd;       // read table entry at index
		logic scr_rd;       // read scratch entry at index
		logic app_do;       // append captured item to table
		logic piece_go;     // scratch append of current piece
		logic [1:0] piece;  // which piece: 0 before, 1 overlap, 2 after, 3 whole entry
		logic idx_inc;      // advance walk index
		logic idx_clr;      // clear walk index and scratch count
		logic cp_start;     // clear table count before copy back
		logic cp_do;        // append scratch entry to table
		logic tot_add;      // accumulate totals
		logic set_fail;     // mark failure
		logic out_load;     // load output register
	} cmd_t;

	typedef struct packed {
		logic range_bad;    // rewrite or reserve range rejected up front
		logic walk_done;    // index reached count
		logic cp_done;      // index reached scratch count
		logic overlap;      // current entry overlaps range
		logic failed;       // failure recorded
		logic covered_ok;   // covered bytes equal length
		logic reserve_zero; // reserve of zero length
	} status_t;

	function automatic logic [51:0] pages_for(input logic [63:0] len);
		pages_for = len[63:PAGE_SHIFT] + {51'd0, (len[PAGE_SHIFT-1:0] != '0)};
	endfunction

	function automatic logic [63:0] end_of(input logic [63:0] b, input logic [51:0] p);
		end_of = b + {p, {PAGE_SHIFT{1'b0}}};
	endfunction

endpackage

FILE: design/page_frame_region_table_core.sv
// Top level of the page frame region table.
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | operation .. attributes
//  out     | output    | out_valid / out_ready | ok .. mmio_pages
// Append reads the last entry and then appends; totals walk the table; rewrite
// and reserve walk the table and then the scratch memory through the single
// read port, or go straight to the result when the range is rejected.
// Reset clears the entry count; no item is taken until the result is loaded.
// The result register holds while out_ready is low.
module page_frame_region_table_core #(
	parameter int MAX_REGIONS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [63:0] base_address,
	input  logic [51:0] page_count,
	input  logic [63:0] length_bytes,
	input  logic [3:0]  page_state,
	input  logic [31:0] usage,
	input  logic [31:0] owner,
	input  logic [31:0] source,
	input  logic [63:0] attributes,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ok,
	output logic [6:0]  entry_count,
	output logic [63:0] total_pages,
	output logic [63:0] free_pages,
	output logic [63:0] reserved_pages,
	output logic [63:0] runtime_pages,
	output logic [63:0] mmio_pages
);
	import pfrt_pkg::*;

	localparam int IDX_W = $clog2(MAX_REGIONS);
	localparam int CNT_W = $clog2(MAX_REGIONS + 1);

	cmd_t    cmd;
	status_t sts;

	pfrt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.op(operation), .sts(sts), .cmd(cmd)
	);

	pfrt_datapath #(.MAX_REGIONS(MAX_REGIONS), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.operation(operation), .base_address(base_address), .page_count(page_count),
		.length_bytes(length_bytes), .page_state(page_state), .usage(usage),
		.owner(owner), .source(source), .attributes(attributes),
		.ok(ok), .entry_count(entry_count), .total_pages(total_pages),
		.free_pages(free_pages), .reserved_pages(reserved_pages),
		.runtime_pages(runtime_pages), .mmio_pages(mmio_pages)
	);

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_in |=> !in_ready) else $error("item accepted while busy");
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(entry_count))
		else $error("result dropped under stall");
	a_single_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.app_do, cmd.cp_do, cmd.piece_go, cmd.tot_add}))
		else $error("conflicting datapath commands");
`endif

endmodule

FILE: design/pfrt_ctrl.sv
// Controller state machine for the page frame region table.
module pfrt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  logic [1:0]       op,
	input  pfrt_pkg::status_t sts,
	output pfrt_pkg::cmd_t   cmd
);
	import pfrt_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					case (op)
						OP_APPEND:  state_d = ST_APP_RD;
						OP_TOTALS:  state_d = ST_TOT_RD;
						default:    state_d = ST_RW_CHK;
					endcase
				end
			end
			ST_APP_RD:  state_d = ST_APP_DO;
			ST_APP_DO:  state_d = ST_DONE;
			ST_RW_CHK:  state_d = (sts.range_bad || sts.reserve_zero) ? ST_DONE : ST_RW_RD;
			ST_RW_RD:   state_d = sts.walk_done ? ST_RW_FIN : ST_RW_WAIT;
			ST_RW_WAIT: state_d = ST_RW_P0;
			ST_RW_P0:   state_d = sts.failed ? ST_DONE : (sts.overlap ? ST_RW_P1 : ST_RW_RD);
			ST_RW_P1:   state_d = sts.failed ? ST_DONE : ST_RW_P2;
			ST_RW_P2:   state_d = sts.failed ? ST_DONE : ST_RW_RD;
			ST_RW_FIN:  state_d = (sts.failed || !sts.covered_ok) ? ST_DONE : ST_CP_RD;
			ST_CP_RD:   state_d = sts.cp_done ? ST_DONE : ST_CP_WAIT;
			ST_CP_WAIT: state_d = ST_CP_DO;
			ST_CP_DO:   state_d = ST_CP_RD;
			ST_TOT_RD:  state_d = sts.walk_done ? ST_DONE : ST_TOT_ADD;
			ST_TOT_ADD: state_d = ST_TOT_RD;
			ST_DONE:    state_d = (!out_valid_q || out_ready) ? ST_IDLE : ST_DONE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:    begin
				cmd.load_in = in_valid && in_ready;
				cmd.idx_clr = 1'b1;
			end
			ST_APP_RD:  cmd.tab_rd = 1'b1;
			ST_APP_DO:  cmd.app_do = 1'b1;
			ST_RW_CHK:  begin
				cmd.rw_setup = 1'b1;
				cmd.set_fail = sts.range_bad;
			end
			ST_RW_RD:   cmd.tab_rd = 1'b1;
			ST_RW_P0:   begin
				cmd.piece_go = 1'b1;
				cmd.piece    = sts.overlap ? 2'd0 : 2'd3;
				cmd.idx_inc  = !sts.overlap;
			end
			ST_RW_P1:   begin
				cmd.piece_go = 1'b1;
				cmd.piece    = 2'd1;
			end
			ST_RW_P2:   begin
				cmd.piece_go = 1'b1;
				cmd.piece    = 2'd2;
				cmd.idx_inc  = 1'b1;
			end
			ST_RW_FIN:  begin
				cmd.set_fail = !sts.covered_ok;
				cmd.cp_start = !sts.failed && sts.covered_ok;
			end
			ST_CP_RD:   cmd.scr_rd = 1'b1;
			ST_CP_DO:   begin
				cmd.cp_do   = 1'b1;
				cmd.idx_inc = 1'b1;
			end
			ST_TOT_RD:  cmd.tab_rd = 1'b1;
			ST_TOT_ADD: begin
				cmd.tot_add = 1'b1;
				cmd.idx_inc = 1'b1;
			end
			ST_DONE:    cmd.out_load = !out_valid_q || out_ready;
			default:    cmd = '0;
		endcase
	end

	// Hold state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

FILE: design/pfrt_datapath.sv
// Datapath for the page frame region table: table and scratch memories, walk and sums.
module pfrt_datapath #(
	parameter int MAX_REGIONS = 64,
	parameter int IDX_W = 6,
	parameter int CNT_W = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pfrt_pkg::cmd_t     cmd,
	output pfrt_pkg::status_t  sts,
	input  logic [1:0]         operation,
	input  logic [63:0]        base_address,
	input  logic [51:0]        page_count,
	input  logic [63:0]        length_bytes,
	input  logic [3:0]         page_state,
	input  logic [31:0]        usage,
	input  logic [31:0]        owner,
	input  logic [31:0]        source,
	input  logic [63:0]        attributes,
	output logic               ok,
	output logic [6:0]         entry_count,
	output logic [63:0]        total_pages,
	output logic [63:0]        free_pages,
	output logic [63:0]        reserved_pages,
	output logic [63:0]        runtime_pages,
	output logic [63:0]        mmio_pages
);
	import pfrt_pkg::*;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REGIONS);

	region_t tab_mem [MAX_REGIONS];
	region_t scr_mem [MAX_REGIONS];

	region_t          in_q, rd_q, scr_last_q, tab_last_q;
	logic [1:0]       op_q;
	logic [63:0]      len_q, rb_q, re_q, cov_q;
	logic [CNT_W-1:0] cnt_q, sc_q, idx_q;
	logic             fail_q;
	logic [63:0]      sum_q [5];

	// Current entry geometry
	logic [63:0] se, ob, oe;
	assign se = end_of(rd_q.base, rd_q.pages);
	assign ob = (rb_q > rd_q.base) ? rb_q : rd_q.base;
	assign oe = (re_q < se) ? re_q : se;
	logic ovl;
	assign ovl = !((se <= rb_q) || (rd_q.base >= re_q));

	// Reserve alignment
	logic [63:0] ab, ae;
	assign ab = {in_q.base[63:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
	logic [63:0] ae_raw;
	assign ae_raw = in_q.base + len_q + 64'(12'hFFF);
	assign ae = {ae_raw[63:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};

	// Piece selection
	region_t piece;
	always_comb begin
		piece = rd_q;
		case (cmd.piece)
			2'd0: piece.pages = pages_for(ob - rd_q.base);
			2'd1: begin
				piece.base  = ob;
				piece.pages = pages_for(oe - ob);
				piece.st    = (op_q == OP_RESERVE) ? 4'd1 : in_q.st;
				piece.usage = in_q.usage;
				piece.owner = in_q.owner;
			end
			2'd2: begin
				piece.base  = oe;
				piece.pages = pages_for(se - oe);
			end
			default: piece = rd_q;
		endcase
	end

	function automatic logic merge_ok(input region_t p, input region_t e);
		merge_ok = end_of(p.base, p.pages) == e.base && p.st == e.st &&
			p.usage == e.usage && p.owner == e.owner &&
			p.source == e.source && p.attrs == e.attrs;
	endfunction

	// Append sources: input item or scratch entry in copy back
	region_t app_e;
	assign app_e = cmd.cp_do ? rd_q : in_q;
	logic tab_merge, scr_merge;
	assign tab_merge = (cnt_q != '0) && merge_ok(tab_last_q, app_e);
	assign scr_merge = (sc_q != '0) && merge_ok(scr_last_q, piece);

	// Memory read index
	logic [IDX_W-1:0] rd_idx;
	assign rd_idx = (op_q == OP_APPEND) ? IDX_W'(cnt_q - 1'b1) : idx_q[IDX_W-1:0];

	// Table and scratch memories
	always_ff @(posedge clk) begin
		if (cmd.tab_rd)
			rd_q <= tab_mem[rd_idx];
		else if (cmd.scr_rd)
			rd_q <= scr_mem[idx_q[IDX_W-1:0]];
		if ((cmd.app_do || cmd.cp_do) && app_e.pages != '0) begin
			if (tab_merge)
				tab_mem[IDX_W'(cnt_q - 1'b1)].pages <= tab_last_q.pages + app_e.pages;
			else if (cnt_q < MAX_CNT)
				tab_mem[cnt_q[IDX_W-1:0]] <= app_e;
		end
		if (cmd.piece_go && piece.pages != '0 && !fail_q) begin
			if (scr_merge)
				scr_mem[IDX_W'(sc_q - 1'b1)].pages <= scr_last_q.pages + piece.pages;
			else if (sc_q < MAX_CNT)
				scr_mem[sc_q[IDX_W-1:0]] <= piece;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q  <= '{base: base_address, pages: page_count, st: page_state,
				usage: usage, owner: owner, source: source, attrs: attributes};
			op_q  <= operation;
			len_q <= length_bytes;
		end
		if (cmd.rw_setup) begin
			if (op_q == OP_RESERVE) begin
				rb_q <= ab;
				re_q <= ae;
			end else begin
				rb_q <= in_q.base;
				re_q <= in_q.base + len_q;
			end
		end
		if (cmd.idx_clr)
			cov_q <= '0;
		else if (cmd.piece_go && cmd.piece == 2'd0)
			cov_q <= cov_q + (oe - ob);
		// Shadow of the last table entry for merge checks
		if ((cmd.app_do || cmd.cp_do) && app_e.pages != '0) begin
			if (tab_merge)
				tab_last_q.pages <= tab_last_q.pages + app_e.pages;
			else if (cnt_q < MAX_CNT)
				tab_last_q <= app_e;
		end
		if (cmd.piece_go && piece.pages != '0 && !fail_q) begin
			if (scr_merge)
				scr_last_q.pages <= scr_last_q.pages + piece.pages;
			else if (sc_q < MAX_CNT)
				scr_last_q <= piece;
		end
		if (cmd.idx_clr) begin
			for (int k = 0; k < 5; k++)
				sum_q[k] <= '0;
		end else if (cmd.tot_add) begin
			sum_q[0] <= sum_q[0] + 64'(rd_q.pages);
			case (rd_q.st)
				4'd0:    sum_q[1] <= sum_q[1] + 64'(rd_q.pages);
				4'd2:    sum_q[3] <= sum_q[3] + 64'(rd_q.pages);
				4'd3:    sum_q[4] <= sum_q[4] + 64'(rd_q.pages);
				default: sum_q[2] <= sum_q[2] + 64'(rd_q.pages);
			endcase
		end
		if (cmd.out_load) begin
			ok             <= !fail_q;
			entry_count    <= 7'(cnt_q);
			total_pages    <= sum_q[0];
			free_pages     <= sum_q[1];
			reserved_pages <= sum_q[2];
			runtime_pages  <= sum_q[3];
			mmio_pages     <= sum_q[4];
		end
	end

	// Control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			sc_q   <= '0;
			idx_q  <= '0;
			fail_q <= 1'b0;
		end else begin
			if (cmd.idx_clr) begin
				idx_q  <= '0;
				sc_q   <= '0;
				fail_q <= 1'b0;
			end else if (cmd.cp_start) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.set_fail)
				fail_q <= 1'b1;
			if (cmd.cp_start)
				cnt_q <= '0;
			if (cmd.app_do && in_q.pages != '0 && !tab_merge) begin
				if (cnt_q < MAX_CNT)
					cnt_q <= cnt_q + 1'b1;
				else
					fail_q <= 1'b1;
			end
			if (cmd.cp_do && app_e.pages != '0 && !tab_merge && cnt_q < MAX_CNT)
				cnt_q <= cnt_q + 1'b1;
			if (cmd.piece_go && piece.pages != '0 && !fail_q && !scr_merge) begin
				if (sc_q < MAX_CNT)
					sc_q <= sc_q + 1'b1;
				else
					fail_q <= 1'b1;
			end
		end
	end

	// Status
	assign sts.reserve_zero = (op_q == OP_RESERVE) && (len_q == '0);
	assign sts.range_bad    = (op_q == OP_RESERVE) ? ((len_q != '0) && (ae <= ab))
		: ((len_q == '0) || ((in_q.base + len_q) <= in_q.base));
	assign sts.walk_done    = (idx_q >= cnt_q);
	assign sts.cp_done      = (idx_q >= sc_q);
	assign sts.overlap      = ovl;
	assign sts.failed       = fail_q;
	assign sts.covered_ok   = (cov_q == (re_q - rb_q));

endmodule
